### rtl/core/hfs_pkg.sv
// ----------------------------------------------------------------------------
// hfs_pkg
// Shared types, constants and the log table of the scaled HMM forward block.
// ----------------------------------------------------------------------------
package hfs_pkg;

    // Probability format is unsigned Q0.16.
    localparam int PROB_BITS      = 16;
    localparam int MAX_STATES_DEF = 256;
    localparam int LN_STEPS       = 16;
    localparam int LN2_Q16        = 45426;

    // Request command codes.
    localparam logic [1:0] CMD_LOAD_TRANS = 2'd0;
    localparam logic [1:0] CMD_LOAD_PRIOR = 2'd1;
    localparam logic [1:0] CMD_EMISSION   = 2'd2;

    // Reset value of the state-count register.
    localparam logic [8:0] NUM_STATES_RST = 9'd256;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic base_prior;
        logic mac_issue;
        logic base_round;
        logic mul;
        logic wr_alpha;
        logic cnt_clr;
        logic cnt_inc;
        logic check;
        logic clr_wr;
        logic lz_init;
        logic lz_step;
        logic ln_load;
        logic ln_step;
        logic ln_fin;
        logic acc_upd;
        logic ndiv_init;
        logic ndiv_step;
        logic nwr;
        logic out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic emit_ok;
        logic emit_first;
        logic cnt_last;
        logic pipe_empty;
        logic last_state;
        logic sum_zero;
        logic lz_done;
        logic sub_ln_last;
        logic sub_div_last;
    } t_stat;

    // ln(1 + 2^-(k+1)) in unsigned Q0.16.
    function automatic logic [15:0] ln_tab(input logic [3:0] idx);
        logic [15:0] v;
        case (idx)
            4'd0:    v = 16'd26573;
            4'd1:    v = 16'd14624;
            4'd2:    v = 16'd7719;
            4'd3:    v = 16'd3973;
            4'd4:    v = 16'd2017;
            4'd5:    v = 16'd1016;
            4'd6:    v = 16'd510;
            4'd7:    v = 16'd256;
            4'd8:    v = 16'd128;
            4'd9:    v = 16'd64;
            4'd10:   v = 16'd32;
            4'd11:   v = 16'd16;
            4'd12:   v = 16'd8;
            4'd13:   v = 16'd4;
            4'd14:   v = 16'd2;
            4'd15:   v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

### rtl/core/hfs_ram.sv
// ----------------------------------------------------------------------------
// hfs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hfs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/hfs_ctrl.sv
// ----------------------------------------------------------------------------
// hfs_ctrl
// Controller state machine: sequences loads, the transition sum, the log
// computation and the normalization of each time step.
// ----------------------------------------------------------------------------
module hfs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  hfs_pkg::t_stat i_stat,
    output hfs_pkg::t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_PRIOR, S_MAC, S_DRAIN, S_ROUND, S_MUL, S_WRITE, S_CHECK,
        S_CLEAR, S_LZ, S_LN, S_LNFIN, S_ACC, S_NRD, S_NINIT, S_NDIV, S_NWR, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_busy;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    if (i_stat.emit_ok) begin
                        n_state = i_stat.emit_first ? S_PRIOR : S_MAC;
                    end
                end
            end
            S_PRIOR: begin
                o_cmd.base_prior = 1'b1;
                n_state = S_MUL;
            end
            S_MAC: begin
                o_cmd.mac_issue = 1'b1;
                o_cmd.cnt_inc   = 1'b1;
                if (i_stat.cnt_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (i_stat.pipe_empty) n_state = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.base_round = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_WRITE;
            end
            S_WRITE: begin
                o_cmd.wr_alpha = 1'b1;
                n_state = i_stat.last_state ? S_CHECK : S_IDLE;
            end
            S_CHECK: begin
                o_cmd.check   = 1'b1;
                o_cmd.cnt_clr = 1'b1;
                if (i_stat.sum_zero) begin
                    n_state = S_CLEAR;
                end else begin
                    o_cmd.lz_init = 1'b1;
                    n_state = S_LZ;
                end
            end
            S_CLEAR: begin
                o_cmd.clr_wr  = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                if (i_stat.cnt_last) n_state = S_OUT;
            end
            S_LZ: begin
                if (i_stat.lz_done) begin
                    o_cmd.ln_load = 1'b1;
                    n_state = S_LN;
                end else begin
                    o_cmd.lz_step = 1'b1;
                end
            end
            S_LN: begin
                o_cmd.ln_step = 1'b1;
                if (i_stat.sub_ln_last) n_state = S_LNFIN;
            end
            S_LNFIN: begin
                o_cmd.ln_fin = 1'b1;
                n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc_upd = 1'b1;
                n_state = S_NRD;
            end
            S_NRD: begin
                n_state = S_NINIT;
            end
            S_NINIT: begin
                o_cmd.ndiv_init = 1'b1;
                n_state = S_NDIV;
            end
            S_NDIV: begin
                o_cmd.ndiv_step = 1'b1;
                if (i_stat.sub_div_last) n_state = S_NWR;
            end
            S_NWR: begin
                o_cmd.nwr     = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                n_state = i_stat.cnt_last ? S_OUT : S_NRD;
            end
            S_OUT: begin
                o_cmd.out = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and busy register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign busy = r_busy;

`ifndef SYNTH
    a_out_after_loop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> ($past(r_state) == S_CLEAR || $past(r_state) == S_NWR))
        else $error("result issued without a finished clear or normalize pass");
    a_div_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NDIV) |-> ($past(r_state) == S_NINIT || $past(r_state) == S_NDIV))
        else $error("divider entered without initialization");
    a_write_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> ($past(r_state) == S_MUL))
        else $error("alpha written without a product");
`endif

endmodule

### rtl/core/hfs_dp.sv
// ----------------------------------------------------------------------------
// hfs_dp
// Datapath: stores, multiply-accumulate pipe, step sum, log unit and the
// bit-serial divider used for normalization.
// ----------------------------------------------------------------------------
module hfs_dp #(
    parameter int MAX_STATES = hfs_pkg::MAX_STATES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [1:0]     i_command,
    input  logic [7:0]     i_state_index,
    input  logic [7:0]     i_from_index,
    input  logic [15:0]    i_prob_value,
    input  logic           i_first_step,
    input  logic           i_last_step,
    input  logic           i_cfg_wr_en,
    input  logic [8:0]     i_cfg_wr_data,
    input  hfs_pkg::t_cmd  i_cmd,
    output hfs_pkg::t_stat o_stat,
    output logic           o_result_valid,
    output logic [31:0]    o_log_likelihood,
    output logic           o_sequence_done,
    output logic           o_zero_sum_error
);

    localparam int PB   = hfs_pkg::PROB_BITS;
    localparam int AW   = $clog2(MAX_STATES);
    localparam int SW   = 2 * PB + AW;
    localparam int PW   = $clog2(SW);
    localparam int SBW  = $clog2(PB + 1);
    localparam int NUMW = 3 * PB + 1;

    // Configuration and latched request.
    logic [8:0]      r_ns;
    logic [AW-1:0]   r_si;
    logic [PB-1:0]   r_prob;
    logic            r_last;
    logic [AW+7:0]   si_wide;
    logic [AW+7:0]   fi_wide;
    logic [AW-1:0]   nm1;

    // Counters.
    logic [AW-1:0]   r_cnt;
    logic [SBW-1:0]  r_sub;

    // Multiply-accumulate pipe.
    logic            r_v1, r_v2;
    logic [2*PB-1:0] r_mprod;
    logic [SW-1:0]   r_acc;
    logic [SW:0]     rnd;

    // Step values.
    logic [PB-1:0]   r_base;
    logic [2*PB-1:0] r_prod;
    logic [SW-1:0]   r_sum;
    logic            r_err;

    // Log unit.
    logic [SW-1:0]   r_y;
    logic [PW-1:0]   r_p;
    logic [31:0]     r_m;
    logic [16:0]     r_r;
    logic [32:0]     ln_t;
    logic signed [31:0] r_ln;
    logic signed [31:0] r_log;
    logic signed [31:0] pe;
    logic signed [32:0] lsum;

    // Divider.
    logic [NUMW-1:0] num;
    logic [SW-1:0]   r_rem;
    logic [PB:0]     r_low;
    logic [PB:0]     r_q;
    logic            r_qsat;
    logic [SW:0]     rem2;
    logic            ge;
    logic [PB-1:0]   nval;

    // Output register.
    logic            r_o_valid;
    logic [31:0]     r_o_ll;
    logic            r_o_done;
    logic            r_o_err;

    // Store ports.
    logic [PB-1:0]   trans_rdata, prior_rdata, aprev_rdata;
    logic [2*PB-1:0] acur_rdata;
    logic            ld_trans, ld_prior;
    logic [PB-1:0]   aprev_wdata;

    assign si_wide = {{AW{1'b0}}, i_state_index};
    assign fi_wide = {{AW{1'b0}}, i_from_index};

    // Active state count minus one, zero as one, clamped to MAX_STATES.
    always_comb begin
        if (r_ns == 9'd0) begin
            nm1 = '0;
        end else if (32'(r_ns) > MAX_STATES) begin
            nm1 = AW'(MAX_STATES - 1);
        end else begin
            nm1 = AW'(32'(r_ns) - 32'd1);
        end
    end

    assign ld_trans = i_cmd.capture && (i_command == hfs_pkg::CMD_LOAD_TRANS)
                      && (32'(i_state_index) < MAX_STATES)
                      && (32'(i_from_index) < MAX_STATES);
    assign ld_prior = i_cmd.capture && (i_command == hfs_pkg::CMD_LOAD_PRIOR)
                      && (32'(i_state_index) < MAX_STATES);

    // Status toward the controller.
    always_comb begin
        o_stat.emit_ok      = (i_command == hfs_pkg::CMD_EMISSION)
                              && (32'(i_state_index) <= 32'(nm1));
        o_stat.emit_first   = i_first_step;
        o_stat.cnt_last     = (r_cnt == nm1);
        o_stat.pipe_empty   = !r_v1 && !r_v2;
        o_stat.last_state   = (r_si == nm1);
        o_stat.sum_zero     = (r_sum == '0);
        o_stat.lz_done      = r_y[SW-1];
        o_stat.sub_ln_last  = (r_sub == SBW'(hfs_pkg::LN_STEPS - 1));
        o_stat.sub_div_last = (r_sub == SBW'(PB));
    end

    // Stores.
    hfs_ram #(.WIDTH(PB), .DEPTH(MAX_STATES * MAX_STATES)) u_trans (
        .i_clk   (i_clk),
        .i_we    (ld_trans),
        .i_waddr ({si_wide[AW-1:0], fi_wide[AW-1:0]}),
        .i_wdata (i_prob_value),
        .i_raddr ({r_si, r_cnt}),
        .o_rdata (trans_rdata)
    );

    hfs_ram #(.WIDTH(PB), .DEPTH(MAX_STATES)) u_prior (
        .i_clk   (i_clk),
        .i_we    (ld_prior),
        .i_waddr (si_wide[AW-1:0]),
        .i_wdata (i_prob_value),
        .i_raddr (si_wide[AW-1:0]),
        .o_rdata (prior_rdata)
    );

    assign aprev_wdata = i_cmd.clr_wr ? '0 : nval;

    hfs_ram #(.WIDTH(PB), .DEPTH(MAX_STATES)) u_aprev (
        .i_clk   (i_clk),
        .i_we    (i_cmd.clr_wr || i_cmd.nwr),
        .i_waddr (r_cnt),
        .i_wdata (aprev_wdata),
        .i_raddr (r_cnt),
        .o_rdata (aprev_rdata)
    );

    hfs_ram #(.WIDTH(2 * PB), .DEPTH(MAX_STATES)) u_acur (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_alpha),
        .i_waddr (r_si),
        .i_wdata (r_prod),
        .i_raddr (r_cnt),
        .o_rdata (acur_rdata)
    );

    // Rounding of the transition sum back to Q0.16 with saturation.
    assign rnd = {1'b0, r_acc} + (SW + 1)'(1 << (PB - 1));

    // One shift-and-add step of the log unit.
    assign ln_t = {1'b0, r_m} + {1'b0, (r_m >> (r_sub + SBW'(1)))};

    // Exponent part of the log.
    assign pe = 32'(r_p) - 32'(2 * PB);

    // Saturating log accumulate.
    assign lsum = {r_log[31], r_log} + {r_ln[31], r_ln};

    // Divider numerator and one restoring step.
    assign num  = {1'b0, acur_rdata, {PB{1'b0}}} + NUMW'(r_sum >> 1);
    assign rem2 = {r_rem, r_low[PB]};
    assign ge   = (rem2 >= {1'b0, r_sum});
    assign nval = (r_qsat || r_q[PB]) ? {PB{1'b1}} : r_q[PB-1:0];

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ns      <= hfs_pkg::NUM_STATES_RST;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_sum     <= '0;
            r_log     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_ns <= i_cfg_wr_data;
            r_v1      <= i_cmd.mac_issue;
            r_v2      <= r_v1;
            r_o_valid <= i_cmd.out;
            if (i_cmd.wr_alpha) r_sum <= r_sum + SW'(r_prod);
            if (i_cmd.acc_upd) begin
                if (lsum[32] != lsum[31]) begin
                    r_log <= lsum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                end else begin
                    r_log <= lsum[31:0];
                end
            end
            if (i_cmd.out) begin
                r_sum <= '0;
                if (r_last) r_log <= '0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_si   <= si_wide[AW-1:0];
            r_prob <= i_prob_value;
            r_last <= i_last_step;
            r_acc  <= '0;
        end
        if (i_cmd.capture || i_cmd.cnt_clr) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + AW'(1);
        end
        if (r_v1) r_mprod <= trans_rdata * aprev_rdata;
        if (r_v2) r_acc <= r_acc + SW'(r_mprod);
        if (i_cmd.base_prior) r_base <= prior_rdata;
        if (i_cmd.base_round) begin
            r_base <= (|rnd[SW:2*PB]) ? {PB{1'b1}} : rnd[2*PB-1:PB];
        end
        if (i_cmd.mul) r_prod <= r_base * r_prob;
        if (i_cmd.check) r_err <= (r_sum == '0);
        // Leading-one search, one bit per cycle.
        if (i_cmd.lz_init) begin
            r_y <= r_sum;
            r_p <= PW'(SW - 1);
        end else if (i_cmd.lz_step) begin
            r_y <= r_y << 1;
            r_p <= r_p - PW'(1);
        end
        // Sub-step counter for the log and the divider.
        if (i_cmd.ln_load || i_cmd.ndiv_init) begin
            r_sub <= '0;
        end else if (i_cmd.ln_step || i_cmd.ndiv_step) begin
            r_sub <= r_sub + SBW'(1);
        end
        if (i_cmd.ln_load) begin
            r_m <= r_y[SW-1 -: 32];
            r_r <= '0;
        end else if (i_cmd.ln_step && !ln_t[32]) begin
            r_m <= ln_t[31:0];
            r_r <= r_r + 17'(hfs_pkg::ln_tab(r_sub[3:0]));
        end
        if (i_cmd.ln_fin) begin
            r_ln <= pe * 32'sd45426 + 32'(hfs_pkg::LN2_Q16) - 32'(r_r);
        end
        // Bit-serial normalizing divide.
        if (i_cmd.ndiv_init) begin
            r_qsat <= (SW'(num[NUMW-1:PB+1]) >= r_sum);
            r_rem  <= SW'(num[NUMW-1:PB+1]);
            r_low  <= num[PB:0];
            r_q    <= '0;
        end else if (i_cmd.ndiv_step) begin
            r_rem <= ge ? SW'(rem2 - {1'b0, r_sum}) : SW'(rem2);
            r_q   <= {r_q[PB-1:0], ge};
            r_low <= r_low << 1;
        end
        if (i_cmd.out) begin
            r_o_ll   <= r_log;
            r_o_done <= r_last;
            r_o_err  <= r_err;
        end
    end

    assign o_result_valid   = r_o_valid;
    assign o_log_likelihood = r_o_ll;
    assign o_sequence_done  = r_o_done;
    assign o_zero_sum_error = r_o_err;

`ifndef SYNTH
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |=> !r_o_valid)
        else $error("result strobe held longer than one cycle");
    a_ln_normalized: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ln_step |-> r_y[SW-1])
        else $error("log steps started on an unnormalized sum");
    a_div_sum_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ndiv_step |-> (r_sum != '0))
        else $error("normalizing divide with a zero step sum");
`endif

endmodule

### rtl/core/hmm_forward_scaled.sv
// ----------------------------------------------------------------------------
// hmm_forward_scaled
// Scaled HMM forward pass in fixed point with a running log likelihood.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Transition and prior
// loads are written when taken. A first-step emission scales the prior; a
// later emission first runs one multiply-accumulate per state through the
// transition and alpha memories. An emission that closes a step then adds the
// leading-one search, the log steps and a bit-serial normalizing divide per
// state; with a zero step sum it clears alpha instead. The result is shown for
// exactly one cycle on o_result_valid and cannot be stalled by the receiver.
module hmm_forward_scaled #(
    parameter int MAX_STATES = hfs_pkg::MAX_STATES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_state_index,
    input  logic [7:0]  i_from_index,
    input  logic [15:0] i_prob_value,
    input  logic        i_first_step,
    input  logic        i_last_step,
    input  logic        i_cfg_wr_en,
    input  logic [8:0]  i_cfg_wr_data,
    output logic        o_result_valid,
    output logic [31:0] o_log_likelihood,
    output logic        o_sequence_done,
    output logic        o_zero_sum_error
);

    hfs_pkg::t_cmd  cmd;
    hfs_pkg::t_stat stat;

    // Sequencer.
    hfs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Stores and arithmetic.
    hfs_dp #(.MAX_STATES(MAX_STATES)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_command        (i_command),
        .i_state_index    (i_state_index),
        .i_from_index     (i_from_index),
        .i_prob_value     (i_prob_value),
        .i_first_step     (i_first_step),
        .i_last_step      (i_last_step),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_result_valid   (o_result_valid),
        .o_log_likelihood (o_log_likelihood),
        .o_sequence_done  (o_sequence_done),
        .o_zero_sum_error (o_zero_sum_error)
    );

endmodule
